// ----- design/sffb_pkg.sv -----
package sffb_pkg;

    // Geometry
    localparam int TAPS_DEF   = 81;
    localparam int NBANKS     = 3;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 40;
    localparam int OUT_LSB    = 16;
    localparam int VOL_W      = 8;
    localparam int BANK_W     = 2;
    localparam int CIDX_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // Coefficient banks
    localparam logic [BANK_W-1:0] BANK_LOW  = 2'd0;
    localparam logic [BANK_W-1:0] BANK_BAND = 2'd1;
    localparam logic [BANK_W-1:0] BANK_HIGH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_BAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME      = 3'd4;

    localparam logic [VOL_W-1:0] VOLUME_RST = 8'd1;

    // History contents before a slot is first written
    localparam logic [SAMPLE_W-1:0] HIST_RST_RIGHT = '0;
    localparam logic [SAMPLE_W-1:0] HIST_RST_LEFT  = '1;

    // Controller -> datapath
    typedef struct packed {
        logic load;    // coefficient load beat accepted
        logic start;   // sample beat accepted
        logic issue;   // one MAC step
        logic finish;  // commit result and history
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic last;      // current step is the final tap, high bank
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

// ----- design/sffb_ram.sv -----
module sffb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sffb_ctrl.sv -----
module sffb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_mode,
    input  logic          i_bypass,
    input  sffb_pkg::t_sts i_sts,
    output sffb_pkg::t_cmd o_cmd
);
    import sffb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RUN    = 5'b00010,
        ST_FLUSH1 = 5'b00100,
        ST_FLUSH2 = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   c_accept;

    assign o_ready  = (r_state == ST_IDLE);
    assign c_accept = i_valid && o_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = c_accept && (i_mode == MODE_LOAD);
        o_cmd.start  = c_accept && (i_mode == MODE_SAMPLE);
        o_cmd.issue  = (r_state == ST_RUN);
        o_cmd.finish = (r_state == ST_FINISH) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = i_bypass ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_sts.last) begin
                    n_state = ST_FLUSH1;
                end
            end
            ST_FLUSH1: n_state = ST_FLUSH2;
            ST_FLUSH2: n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A sample beat always leaves idle for the MAC loop or the result stage
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_RUN || r_state == ST_FINISH))
        else $error("sample beat did not start processing");

endmodule

// ----- design/sffb_dp.sv -----
module sffb_dp #(
    parameter int TAPS = sffb_pkg::TAPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sffb_pkg::t_cmd                      i_cmd,
    output sffb_pkg::t_sts                      o_sts,
    input  logic                                i_channel,
    input  logic signed [sffb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [sffb_pkg::BANK_W-1:0]         i_bank,
    input  logic [sffb_pkg::CIDX_W-1:0]         i_coef_index,
    input  logic signed [sffb_pkg::COEF_W-1:0]  i_coef_value,
    input  logic                                i_en_low,
    input  logic                                i_en_band,
    input  logic                                i_en_high,
    input  logic                                i_bypass,
    input  logic [sffb_pkg::VOL_W-1:0]          i_volume,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_channel_out,
    output logic signed [sffb_pkg::SAMPLE_W-1:0] o_filtered
);
    import sffb_pkg::*;

    localparam int HD   = TAPS - 1;                    // history depth per channel
    localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;   // slot address bits
    localparam int HDEP = 2 << HAW;                    // both channels, {ch, slot}
    localparam int KW   = $clog2(TAPS);
    localparam int CDEP = NBANKS * TAPS;
    localparam int CAW  = $clog2(CDEP);
    localparam int BYW  = SAMPLE_W + VOL_W;

    function automatic logic [CAW-1:0] bank_base(input logic [BANK_W-1:0] b);
        logic [CAW-1:0] base;
        case (b)
            BANK_BAND: base = CAW'(TAPS);
            BANK_HIGH: base = CAW'(2 * TAPS);
            default:   base = '0;
        endcase
        return base;
    endfunction

    function automatic logic [HAW-1:0] slot_prev(input logic [HAW-1:0] s);
        return (s == '0) ? HAW'(HD - 1) : s - 1'b1;
    endfunction

    function automatic logic [HAW-1:0] slot_next(input logic [HAW-1:0] s);
        return (s == HAW'(HD - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W-PROD_W+1){p[PROD_W-1]}}, p};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

    // item state
    logic                        r_ch;
    logic signed [SAMPLE_W-1:0]  r_x;
    logic [HAW-1:0]              r_wp   [2];
    logic [KW-1:0]               r_fill [2];

    // step counters
    logic [KW-1:0]      r_k;
    logic [BANK_W-1:0]  r_b;
    logic [HAW-1:0]     r_rp;

    // pipeline
    logic r_a_vld, r_a_k0, r_a_live, r_a_en;
    logic signed [PROD_W-1:0] r_prod;
    logic r_b_en;
    logic signed [ACC_W-1:0]  r_acc;

    // output register
    logic                        r_out_valid;
    logic                        r_out_ch;
    logic signed [SAMPLE_W-1:0]  r_out_val;

    logic                  c_en;
    logic                  c_load_ok;
    logic [CAW-1:0]        c_coef_waddr;
    logic [CAW-1:0]        c_coef_raddr;
    logic [COEF_W-1:0]     c_coef_rdata;
    logic [SAMPLE_W-1:0]   c_hist_rdata;
    logic signed [SAMPLE_W-1:0] c_samp;
    logic [BYW-1:0]        c_byp;

    always_comb begin
        case (r_b)
            BANK_LOW:  c_en = i_en_low;
            BANK_BAND: c_en = i_en_band;
            BANK_HIGH: c_en = i_en_high;
            default:   c_en = 1'b0;
        endcase
    end

    assign c_load_ok    = (i_bank <= BANK_HIGH) && (int'(i_coef_index) < TAPS);
    assign c_coef_waddr = bank_base(i_bank) + CAW'(i_coef_index);
    assign c_coef_raddr = bank_base(r_b) + CAW'(TAPS - 1) - CAW'(r_k);

    sffb_ram #(.WIDTH(COEF_W), .DEPTH(CDEP)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && c_load_ok),
        .i_waddr (c_coef_waddr),
        .i_wdata (i_coef_value),
        .i_raddr (c_coef_raddr),
        .o_rdata (c_coef_rdata)
    );

    sffb_ram #(.WIDTH(SAMPLE_W), .DEPTH(HDEP)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr ({r_ch, r_wp[r_ch]}),
        .i_wdata (r_x),
        .i_raddr ({r_ch, r_rp}),
        .o_rdata (c_hist_rdata)
    );

    // tap 0 is the new sample; slots beyond the fill count hold reset contents
    always_comb begin
        if (r_a_k0) begin
            c_samp = r_x;
        end else if (r_a_live) begin
            c_samp = c_hist_rdata;
        end else begin
            c_samp = r_ch ? HIST_RST_LEFT : HIST_RST_RIGHT;
        end
    end

    assign c_byp = {{VOL_W{1'b0}}, r_x} * {{SAMPLE_W{1'b0}}, i_volume};

    // payload capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ch <= i_channel;
            r_x  <= i_sample;
        end
        r_prod <= c_samp * $signed(c_coef_rdata);
        if (i_cmd.finish) begin
            r_out_ch  <= r_ch;
            r_out_val <= i_bypass ? c_byp[SAMPLE_W-1:0] : r_acc[OUT_LSB +: SAMPLE_W];
        end
    end

    // step counters and stage A flags
    always_ff @(posedge i_clk) begin
        r_a_k0   <= (r_k == '0);
        r_a_live <= (r_k <= r_fill[r_ch]);
        r_a_en   <= c_en;
        if (i_cmd.start) begin
            r_k  <= '0;
            r_b  <= BANK_LOW;
            r_rp <= slot_prev(r_wp[i_channel]);
        end else if (i_cmd.issue) begin
            if (r_b == BANK_HIGH) begin
                r_b <= BANK_LOW;
                r_k <= r_k + KW'(1);
                if (r_k != '0) begin
                    r_rp <= slot_prev(r_rp);
                end
            end else begin
                r_b <= r_b + BANK_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_en      <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_wp[0]     <= '0;
            r_wp[1]     <= '0;
            r_fill[0]   <= '0;
            r_fill[1]   <= '0;
        end else begin
            r_a_vld <= i_cmd.issue;
            r_b_en  <= r_a_vld && r_a_en;
            if (i_cmd.start) begin
                r_acc <= '0;
            end else if (r_b_en) begin
                r_acc <= sat_add(r_acc, r_prod);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_wp[r_ch]  <= slot_next(r_wp[r_ch]);
                if (r_fill[r_ch] != KW'(HD)) begin
                    r_fill[r_ch] <= r_fill[r_ch] + KW'(1);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.last     = (r_k == KW'(TAPS - 1)) && (r_b == BANK_HIGH);
        o_sts.out_free = !r_out_valid || i_ready;
    end

    assign o_valid       = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_filtered    = r_out_val;

    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.start && !r_b_en) |=> $stable(r_acc))
        else $error("accumulator moved with no product pending");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item not presented");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= KW'(HD)) && (r_fill[1] <= KW'(HD)))
        else $error("history fill count past depth");

endmodule

// ----- design/stereo_fir_filter_bank.sv -----
// Two-channel FIR filter bank. A mode-0 beat carries one 16-bit sample of the
// right (0) or left (1) channel; one result beat follows with the channel and
// the output sample. Each enabled bank (low, band, high pass) adds
// sample(k) * coef[bank][TAPS-1-k] into a 40-bit accumulator, tap by tap from
// the newest sample, low/band/high within a tap, saturating on every add; the
// result is accumulator bits 31..16. With bypass set the result is instead the
// low 16 bits of volume * sample. Either way the sample then joins its
// channel's history (right starts all zeros, left all -1). A mode-1 beat
// loads one coefficient and gives no result; loads with bank 3 or an index of
// TAPS or more are dropped. Coefficients must be loaded before they are used.
// Timing: one multiply-accumulate per cycle through a single multiplier fed by
// the coefficient memory's one read port, so a filtered sample holds the input
// through the MAC loop, the flush states and the commit, a bypassed sample
// through the commit only. Input ready is high only between items; a result
// waiting in the output register does not hold off the next input beat.
// Configuration writes are meant for idle periods only.
module stereo_fir_filter_bank #(
    parameter int TAPS = sffb_pkg::TAPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input beats
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic                                  i_channel,
    input  logic signed [sffb_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [sffb_pkg::BANK_W-1:0]           i_bank,
    input  logic [sffb_pkg::CIDX_W-1:0]           i_coef_index,
    input  logic signed [sffb_pkg::COEF_W-1:0]    i_coef_value,
    // result beats
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_channel_out,
    output logic signed [sffb_pkg::SAMPLE_W-1:0]  o_filtered,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [sffb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sffb_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import sffb_pkg::*;

    logic               r_en_low;
    logic               r_en_band;
    logic               r_en_high;
    logic               r_bypass;
    logic [VOL_W-1:0]   r_volume;

    t_cmd c_cmd;
    t_sts c_sts;

    // Config registers; unknown indexes fall through and are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_low  <= 1'b0;
            r_en_band <= 1'b0;
            r_en_high <= 1'b0;
            r_bypass  <= 1'b0;
            r_volume  <= VOLUME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE_LOW:  r_en_low  <= i_cfg_data[0];
                CFG_ENABLE_BAND: r_en_band <= i_cfg_data[0];
                CFG_ENABLE_HIGH: r_en_high <= i_cfg_data[0];
                CFG_BYPASS:      r_bypass  <= i_cfg_data[0];
                CFG_VOLUME:      r_volume  <= i_cfg_data[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: idle -> MAC loop (3*TAPS steps) -> flush1, flush2 -> commit
    sffb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_mode   (i_mode),
        .i_bypass (r_bypass),
        .i_sts    (c_sts),
        .o_cmd    (c_cmd)
    );

    // Coefficient and history memories, MAC pipeline, output register
    sffb_dp #(.TAPS(TAPS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (c_cmd),
        .o_sts         (c_sts),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .i_bank        (i_bank),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_en_low      (r_en_low),
        .i_en_band     (r_en_band),
        .i_en_high     (r_en_high),
        .i_bypass      (r_bypass),
        .i_volume      (r_volume),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_channel_out (o_channel_out),
        .o_filtered    (o_filtered)
    );

endmodule
